@@ src/zeaq_pkg.sv @@
`default_nettype none

package zeaq_pkg;

  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned SQ_BITS    = 2 * COORD_BITS;
  localparam int unsigned DIST_BITS  = SQ_BITS + 1;
  localparam int unsigned MS_BITS    = 16;
  localparam int unsigned ACC_BITS   = 20;
  localparam int unsigned IDX_BITS   = 3;
  localparam int unsigned CFG_BITS   = 16;

  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  // register map
  localparam logic [IDX_BITS-1:0] CFG_CENTER_X   = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_ZONE_RAD   = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_ALARM_HOLD = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_COOLDOWN   = 3'd4;
  localparam logic [IDX_BITS-1:0] CFG_GRACE      = 3'd5;

  localparam logic [COORD_BITS-1:0] CENTER_X_RST   = COORD_BITS'(330);
  localparam logic [COORD_BITS-1:0] CENTER_Y_RST   = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] ZONE_RAD_RST   = COORD_BITS'(1);
  localparam logic [MS_BITS-1:0]    ALARM_HOLD_RST = MS_BITS'(800);
  localparam logic [MS_BITS-1:0]    COOLDOWN_RST   = MS_BITS'(3000);
  localparam logic [MS_BITS-1:0]    GRACE_RST      = MS_BITS'(500);

  // item kinds
  localparam logic ACT_DETECT = 1'b0;
  localparam logic ACT_EOF    = 1'b1;

  typedef enum logic [2:0] {
    ST_SEARCHING = 3'd0,
    ST_NO_HOOK   = 3'd1,
    ST_READY     = 3'd2,
    ST_COOLING   = 3'd3,
    ST_ALARMED   = 3'd4
  } status_e;

  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                  input logic [MS_BITS-1:0]  b);
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + (ACC_BITS+1)'(b);
    return s[ACC_BITS] ? ACC_MAX : s[ACC_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/zone_exit_alarm_qualifier_core.sv @@
// An end-of-frame word passes through the input register, the squares register and the
// result register before it shows on the result port; detection words give no result.
// Throughput: one word per cycle; the input stays open while a result waits, until
// the pipeline behind it is full.
// Reset (rst_ni, async, active low): all tracking state cleared, registers to defaults.
`default_nettype none

module zone_exit_alarm_qualifier_core import zeaq_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [CFG_BITS-1:0]   cfg_wdata_i,
  // input words
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  action_i,
  input  wire logic                  is_hook_i,
  input  wire logic [COORD_BITS-1:0] point_x_i,
  input  wire logic [COORD_BITS-1:0] point_y_i,
  input  wire logic [TIME_BITS-1:0]  time_ms_i,
  input  wire logic [MS_BITS-1:0]    frame_interval_ms_i,
  // result words
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [2:0]            status_o,
  output      logic                  zone_alarm_colour_o,
  output      logic                  alarm_pulse_o,
  output      logic                  latched_o,
  output      logic [ACC_BITS-1:0]   outside_time_ms_o,
  output      logic [ACC_BITS-1:0]   inside_time_ms_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] center_x_q, center_y_q, zone_rad_q;
  logic [MS_BITS-1:0]    alarm_hold_q, cooldown_q, grace_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= CENTER_X_RST;
      center_y_q   <= CENTER_Y_RST;
      zone_rad_q   <= ZONE_RAD_RST;
      alarm_hold_q <= ALARM_HOLD_RST;
      cooldown_q   <= COOLDOWN_RST;
      grace_q      <= GRACE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTER_X:   center_x_q   <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_CENTER_Y:   center_y_q   <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_ZONE_RAD:   zone_rad_q   <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_ALARM_HOLD: alarm_hold_q <= cfg_wdata_i[MS_BITS-1:0];
        CFG_COOLDOWN:   cooldown_q   <= cfg_wdata_i[MS_BITS-1:0];
        CFG_GRACE:      grace_q      <= cfg_wdata_i[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Stage A holds the accepted word, stage B the squares, then the
  // result register. A detection leaves stage B without needing the result slot.
  // ---------------------------------------------------------------------------
  logic va_q, vb_q, ov_q;
  logic a_act_q, a_hook_q;
  logic b_act_q, b_hook_q;
  logic out_free, b_adv, b_ready, a_ready, in_acc, load_out;

  assign out_free   = !ov_q || out_ready_i;
  assign b_adv      = vb_q && ((b_act_q == ACT_DETECT) || out_free);
  assign b_ready    = !vb_q || b_adv;
  assign a_ready    = !va_q || b_ready;
  assign in_ready_o = a_ready;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_out   = b_adv && (b_act_q == ACT_EOF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (a_ready) va_q <= in_valid_i;
      if (b_ready) vb_q <= va_q;
      if (load_out)         ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: accepted word
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] a_px_q, a_py_q;
  logic [TIME_BITS-1:0]  a_time_q;
  logic [MS_BITS-1:0]    a_dt_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_act_q  <= action_i;
      a_hook_q <= is_hook_i;
      a_px_q   <= point_x_i;
      a_py_q   <= point_y_i;
      a_time_q <= time_ms_i;
      a_dt_q   <= frame_interval_ms_i;
    end
  end

  // absolute differences and squares, one multiplier each
  logic [COORD_BITS-1:0] dx, dy;
  assign dx = (a_px_q >= center_x_q) ? (a_px_q - center_x_q) : (center_x_q - a_px_q);
  assign dy = (a_py_q >= center_y_q) ? (a_py_q - center_y_q) : (center_y_q - a_py_q);

  logic [SQ_BITS-1:0]   b_dx2_q, b_dy2_q, b_r2_q;
  logic [TIME_BITS-1:0] b_time_q;
  logic [MS_BITS-1:0]   b_dt_q;

  always_ff @(posedge clk_i) begin
    if (b_ready && va_q) begin
      b_act_q  <= a_act_q;
      b_hook_q <= a_hook_q;
      b_dx2_q  <= SQ_BITS'(dx) * SQ_BITS'(dx);
      b_dy2_q  <= SQ_BITS'(dy) * SQ_BITS'(dy);
      b_r2_q   <= SQ_BITS'(zone_rad_q) * SQ_BITS'(zone_rad_q);
      b_time_q <= a_time_q;
      b_dt_q   <= a_dt_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: frame gather, alarm qualification, result
  // ---------------------------------------------------------------------------
  logic                 found_q, found_d, fout_q, fout_d;
  logic                 active_q, active_d, latch_q, latch_d, cool_q, cool_d;
  logic [TIME_BITS-1:0] seen_q, seen_d, ostart_q, ostart_d, cstart_q, cstart_d;
  logic [ACC_BITS-1:0]  oacc_q, oacc_d, iacc_q, iacc_d;

  logic [DIST_BITS-1:0] d2;
  logic                 is_out;
  logic [TIME_BITS-1:0] el_seen, el_out, el_cool;
  logic                 grace_now, pulse, colour;
  status_e              status;

  assign d2     = DIST_BITS'(b_dx2_q) + DIST_BITS'(b_dy2_q);
  assign is_out = d2 > DIST_BITS'(b_r2_q);

  assign el_seen   = b_time_q - seen_q;
  assign grace_now = !found_q && (el_seen <= TIME_BITS'(grace_q));
  // a fresh outside run starts now, so it has zero elapsed time
  assign el_out   = active_q ? (b_time_q - ostart_q) : '0;
  assign el_cool  = b_time_q - cstart_q;
  assign colour   = fout_q || (grace_now && active_q);

  always_comb begin
    if (grace_now)     status = ST_SEARCHING;
    else if (!found_q) status = ST_NO_HOOK;
    else if (!latch_q) status = ST_READY;
    else if (cool_q)   status = ST_COOLING;
    else               status = ST_ALARMED;
  end

  always_comb begin
    found_d  = found_q;
    fout_d   = fout_q;
    active_d = active_q;
    latch_d  = latch_q;
    cool_d   = cool_q;
    seen_d   = seen_q;
    ostart_d = ostart_q;
    cstart_d = cstart_q;
    oacc_d   = oacc_q;
    iacc_d   = iacc_q;
    pulse    = 1'b0;
    if (b_adv) begin
      if (b_act_q == ACT_DETECT) begin
        if (b_hook_q) begin
          found_d = 1'b1;
          if (is_out) fout_d = 1'b1;
        end
      end else begin
        found_d = 1'b0;
        fout_d  = 1'b0;
        if (found_q) seen_d = b_time_q;
        if (!grace_now) begin
          if (fout_q) begin
            cool_d = 1'b0;
            iacc_d = '0;
            if (!active_q) begin
              active_d = 1'b1;
              ostart_d = b_time_q;
            end
            if (!latch_q) begin
              oacc_d = sat_add(oacc_q, b_dt_q);
              if (el_out >= TIME_BITS'(alarm_hold_q)) begin
                latch_d = 1'b1;
                pulse   = 1'b1;
              end
            end
          end else begin
            active_d = 1'b0;
            if (!latch_q) oacc_d = '0;
            if (latch_q && found_q) begin
              iacc_d = sat_add(iacc_q, b_dt_q);
              if (!cool_q) begin
                cool_d   = 1'b1;
                cstart_d = b_time_q;
              end else if (el_cool >= TIME_BITS'(cooldown_q)) begin
                // held inside long enough: drop the latch
                latch_d = 1'b0;
                cool_d  = 1'b0;
                oacc_d  = '0;
                iacc_d  = '0;
              end
            end else begin
              cool_d = 1'b0;
              iacc_d = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      fout_q   <= 1'b0;
      active_q <= 1'b0;
      latch_q  <= 1'b0;
      cool_q   <= 1'b0;
      seen_q   <= '0;
      ostart_q <= '0;
      cstart_q <= '0;
      oacc_q   <= '0;
      iacc_q   <= '0;
    end else begin
      found_q  <= found_d;
      fout_q   <= fout_d;
      active_q <= active_d;
      latch_q  <= latch_d;
      cool_q   <= cool_d;
      seen_q   <= seen_d;
      ostart_q <= ostart_d;
      cstart_q <= cstart_d;
      oacc_q   <= oacc_d;
      iacc_q   <= iacc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: values before this frame's update, pulse from this frame
  // ---------------------------------------------------------------------------
  status_e             r_status_q;
  logic                r_colour_q, r_pulse_q, r_latched_q;
  logic [ACC_BITS-1:0] r_oacc_q, r_iacc_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      r_status_q  <= status;
      r_colour_q  <= colour;
      r_pulse_q   <= pulse;
      r_latched_q <= latch_q;
      r_oacc_q    <= oacc_q;
      r_iacc_q    <= iacc_q;
    end
  end

  assign out_valid_o         = ov_q;
  assign status_o            = r_status_q;
  assign zone_alarm_colour_o = r_colour_q;
  assign alarm_pulse_o       = r_pulse_q;
  assign latched_o           = r_latched_q;
  assign outside_time_ms_o   = r_oacc_q;
  assign inside_time_ms_o    = r_iacc_q;

endmodule

`default_nettype wire
